>>> hdl/fsc_pkg.sv
// ---------------------------------------------------------------------------
// fsc_pkg
// Types, codes and helpers shared by the free segment coalescer.
// ---------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

	localparam int ADDR_BITS        = 20;
	localparam int LEN_BITS         = ADDR_BITS + 1;
	localparam int DEF_MAX_SEGMENTS = 16;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [LEN_BITS-1:0]  len_t;

	typedef enum logic [1:0] {
		REQ_LOAD    = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_DUMP    = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		req_type_t req_type;
		addr_t     seg_start;
		len_t      seg_length;
	} req_t;

	typedef struct packed {
		status_t status;
		addr_t   out_start;
		len_t    out_length;
		logic    last;
	} rsp_t;

	typedef struct packed {
		addr_t start;
		len_t  length;
	} seg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT_DN,
		S_SHIFT_UP,
		S_INSERT,
		S_RESP,
		S_DUMP
	} state_t;

	// saturating length add
	function automatic len_t sat_add(input len_t a, input len_t b);
		logic [LEN_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/free_segment_coalescer_top.sv
// Load: writes its entry on accept when there is room, then registers its status word.
// Release: scans, reading one entry a cycle up to the insert point, then decides; a double
// merge shifts later entries down and a mid insert shifts them up (then writes the new entry),
// one entry a cycle. Dump: one word per segment, read and registered, one word per cycle
// while not stalled. One item at a time, set by the single read and write port of the table.
// Reset clears the segment count and output valid; table contents are left as they are.
// ---------------------------------------------------------------------------
// free_segment_coalescer_top
// Address-ordered free segment table with merge on release and ordered dump.
// ---------------------------------------------------------------------------
`default_nettype none

module free_segment_coalescer_top import fsc_pkg::*; #(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	typedef logic [CW-1:0] cnt_t;

	localparam cnt_t MAX_CNT = CW'(MAX_SEGMENTS);
	localparam cnt_t ONE     = CW'(1);
	localparam cnt_t TWO     = CW'(2);

	state_t  state_q, state_d;
	cnt_t    cnt_q, cnt_d;
	logic    rsp_valid_q, rsp_valid_d;

	cnt_t    ci_q, ci_d;
	cnt_t    pos_q, pos_d;
	addr_t   a_q, a_d;
	len_t    len_q, len_d;
	seg_t    prev_q, prev_d;
	seg_t    next_q, next_d;
	len_t    pl_q, pl_d;
	logic    hp_q, hp_d;
	logic    hn_q, hn_d;
	status_t status_q, status_d;
	rsp_t    rsp_q, rsp_d;

	logic    we;
	cnt_t    waddr;
	seg_t    wdata;
	cnt_t    raddr;
	seg_t    rdata;

	logic              slot_free;
	logic [LEN_BITS:0] prev_end;
	logic [LEN_BITS:0] new_end;
	logic              mprev;
	logic              mnext;
	len_t              pn_len;
	len_t              nl_len;

	fsc_seg_ram #(
		.DEPTH (MAX_SEGMENTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr[IW-1:0]),
		.wdata (wdata),
		.raddr (raddr[IW-1:0]),
		.rdata (rdata)
	);

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign prev_end  = {1'b0, {(LEN_BITS-ADDR_BITS){1'b0}}, prev_q.start}
	                 + {1'b0, prev_q.length};
	assign new_end   = {1'b0, {(LEN_BITS-ADDR_BITS){1'b0}}, a_q} + {1'b0, len_q};
	assign mprev     = hp_q && (prev_end == {2'b00, a_q});
	assign mnext     = hn_q && (new_end == {2'b00, next_q.start});
	assign pn_len    = sat_add(pl_q, next_q.length);
	assign nl_len    = sat_add(next_q.length, len_q);

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		rsp_valid_d = rsp_valid_q;
		ci_d        = ci_q;
		pos_d       = pos_q;
		a_d         = a_q;
		len_d       = len_q;
		prev_d      = prev_q;
		next_d      = next_q;
		pl_d        = pl_q;
		hp_d        = hp_q;
		hn_d        = hn_q;
		status_d    = status_q;
		rsp_d       = rsp_q;
		we          = 1'b0;
		waddr       = '0;
		wdata       = '0;
		raddr       = '0;

		if (rsp_valid_q && rsp_ready) begin
			rsp_valid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					a_d   = req.seg_start;
					len_d = req.seg_length;
					hp_d  = 1'b0;
					hn_d  = 1'b0;
					ci_d  = '0;
					pos_d = '0;
					unique case (req.req_type)
						REQ_LOAD: begin
							if (cnt_q == MAX_CNT) begin
								status_d = ST_FULL;
							end else begin
								we       = 1'b1;
								waddr    = cnt_q;
								wdata    = '{start: req.seg_start, length: req.seg_length};
								cnt_d    = cnt_q + ONE;
								status_d = ST_OK;
							end
							state_d = S_RESP;
						end
						REQ_RELEASE: begin
							state_d = (cnt_q == '0) ? S_DECIDE : S_SCAN;
						end
						REQ_DUMP: begin
							if (cnt_q == '0) begin
								status_d = ST_EMPTY;
								state_d  = S_RESP;
							end else begin
								state_d = S_DUMP;
							end
						end
						default: ;
					endcase
				end
			end

			S_SCAN: begin
				if (rdata.start < a_q) begin
					prev_d = rdata;
					pl_d   = sat_add(rdata.length, len_q);
					hp_d   = 1'b1;
					if (ci_q + ONE == cnt_q) begin
						pos_d   = cnt_q;
						state_d = S_DECIDE;
					end else begin
						ci_d  = ci_q + ONE;
						raddr = ci_q + ONE;
					end
				end else begin
					next_d  = rdata;
					hn_d    = 1'b1;
					pos_d   = ci_q;
					state_d = S_DECIDE;
				end
			end

			S_DECIDE: begin
				status_d = ST_OK;
				state_d  = S_RESP;
				priority if (mprev && mnext) begin
					we    = 1'b1;
					waddr = pos_q - ONE;
					wdata = '{start: prev_q.start, length: pn_len};
					if (pos_q + ONE == cnt_q) begin
						cnt_d = cnt_q - ONE;
					end else begin
						raddr   = pos_q + ONE;
						ci_d    = pos_q;
						state_d = S_SHIFT_DN;
					end
				end else if (mprev) begin
					we    = 1'b1;
					waddr = pos_q - ONE;
					wdata = '{start: prev_q.start, length: pl_q};
				end else if (mnext) begin
					we    = 1'b1;
					waddr = pos_q;
					wdata = '{start: a_q, length: nl_len};
				end else if (cnt_q == MAX_CNT) begin
					status_d = ST_FULL;
				end else if (pos_q == cnt_q) begin
					we    = 1'b1;
					waddr = pos_q;
					wdata = '{start: a_q, length: len_q};
					cnt_d = cnt_q + ONE;
				end else begin
					raddr   = cnt_q - ONE;
					ci_d    = cnt_q;
					state_d = S_SHIFT_UP;
				end
			end

			S_SHIFT_DN: begin
				we    = 1'b1;
				waddr = ci_q;
				wdata = rdata;
				if (ci_q + TWO == cnt_q) begin
					cnt_d   = cnt_q - ONE;
					state_d = S_RESP;
				end else begin
					ci_d  = ci_q + ONE;
					raddr = ci_q + TWO;
				end
			end

			S_SHIFT_UP: begin
				we    = 1'b1;
				waddr = ci_q;
				wdata = rdata;
				if (ci_q - ONE == pos_q) begin
					state_d = S_INSERT;
				end else begin
					ci_d  = ci_q - ONE;
					raddr = ci_q - TWO;
				end
			end

			S_INSERT: begin
				we      = 1'b1;
				waddr   = pos_q;
				wdata   = '{start: a_q, length: len_q};
				cnt_d   = cnt_q + ONE;
				state_d = S_RESP;
			end

			S_RESP: begin
				if (slot_free) begin
					rsp_valid_d = 1'b1;
					rsp_d       = '{status: status_q, out_start: '0, out_length: '0, last: 1'b1};
					state_d     = S_IDLE;
				end
			end

			S_DUMP: begin
				raddr = ci_q;
				if (slot_free) begin
					rsp_valid_d = 1'b1;
					rsp_d       = '{status: ST_OK, out_start: rdata.start,
					                out_length: rdata.length, last: (ci_q + ONE == cnt_q)};
					if (ci_q + ONE == cnt_q) begin
						state_d = S_IDLE;
					end else begin
						ci_d  = ci_q + ONE;
						raddr = ci_q + ONE;
					end
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ci_q     <= ci_d;
		pos_q    <= pos_d;
		a_q      <= a_d;
		len_q    <= len_d;
		prev_q   <= prev_d;
		next_q   <= next_d;
		pl_q     <= pl_d;
		hp_q     <= hp_d;
		hn_q     <= hn_d;
		status_q <= status_d;
		rsp_q    <= rsp_d;
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> hdl/fsc_seg_ram.sv
// ---------------------------------------------------------------------------
// fsc_seg_ram
// Segment table storage: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module fsc_seg_ram import fsc_pkg::*; #(
	parameter int DEPTH = DEF_MAX_SEGMENTS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire seg_t          wdata,
	input  wire logic [AW-1:0] raddr,
	output seg_t               rdata
);

	seg_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/fsc_checker.sv
// ---------------------------------------------------------------------------
// fsc_checker
// Port-level checks for the free segment coalescer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module fsc_checker import fsc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	// stalled word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// a real request closes the input until it is done
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.req_type == REQ_LOAD ||
		req.req_type == REQ_RELEASE || req.req_type == REQ_DUMP) |=> !req_ready)
		else $error("input accepted while a request is in progress");

	// status words carry no segment and close the item
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |->
		rsp.last && rsp.out_start == '0 && rsp.out_length == '0)
		else $error("status word malformed");

	// dump in progress keeps input closed
	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> !req_ready)
		else $error("input open during dump");

endmodule

bind free_segment_coalescer_top fsc_checker u_fsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

>>> tb/sv/tb_free_segment_coalescer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_free_segment_coalescer_top
// Checks the free segment coalescer against a behavioral copy of its table.
// Directed tests cover the empty dump, ignored request codes, every kind of
// merge, address and length extremes, out-of-order loads and a full table.
// A random phase then drives load/release/dump traffic and some unknown codes,
// with random gaps and stalls on both channels, but for a steady stretch. Every
// response word is compared field by field against a queue of predicted words.
// ---------------------------------------------------------------------------

module tb_free_segment_coalescer_top;
	import fsc_pkg::*;

	localparam int         TABLE_DEPTH = DEF_MAX_SEGMENTS;
	localparam int         ADDR_MAX    = (1 << ADDR_BITS) - 1;
	localparam int         LEN_MAX     = 1 << ADDR_BITS;
	localparam req_type_t  REQ_UNKNOWN = req_type_t'(2'd3);

	typedef logic [LEN_BITS:0] span_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	bit   steady;
	int   mismatches;

	seg_t seg_table [TABLE_DEPTH];
	int   seg_count;
	rsp_t expected_words [$];

	free_segment_coalescer_top #(
		.MAX_SEGMENTS(TABLE_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic span_t segment_end(input seg_t s);
		return span_t'(s.start) + span_t'(s.length);
	endfunction

	function automatic len_t clamp_sum(input len_t a, input len_t b);
		span_t s;
		s = span_t'(a) + span_t'(b);
		if (s > span_t'({LEN_BITS{1'b1}}))
			return {LEN_BITS{1'b1}};
		return s[LEN_BITS-1:0];
	endfunction

	// table update and expected words for one accepted request
	function automatic void predict_request(input req_t r);
		rsp_t  w;
		int    pos;
		span_t new_end;
		bit    join_prev;
		bit    join_next;
		w = '{status: ST_OK, out_start: '0, out_length: '0, last: 1'b1};
		case (r.req_type)
			REQ_LOAD: begin
				if (seg_count >= TABLE_DEPTH) begin
					w.status = ST_FULL;
				end else begin
					seg_table[seg_count] = '{start: r.seg_start, length: r.seg_length};
					seg_count++;
				end
			end
			REQ_RELEASE: begin
				pos = 0;
				while (pos < seg_count && seg_table[pos].start < r.seg_start)
					pos++;
				new_end   = span_t'(r.seg_start) + span_t'(r.seg_length);
				join_prev = pos > 0 && segment_end(seg_table[pos-1]) == span_t'(r.seg_start);
				join_next = pos < seg_count && new_end == span_t'(seg_table[pos].start);
				if (join_prev && join_next) begin
					seg_table[pos-1].length = clamp_sum(clamp_sum(seg_table[pos-1].length,
						r.seg_length), seg_table[pos].length);
					for (int i = pos; i + 1 < seg_count; i++)
						seg_table[i] = seg_table[i+1];
					seg_count--;
				end else if (join_prev) begin
					seg_table[pos-1].length = clamp_sum(seg_table[pos-1].length, r.seg_length);
				end else if (join_next) begin
					seg_table[pos].start  = r.seg_start;
					seg_table[pos].length = clamp_sum(seg_table[pos].length, r.seg_length);
				end else if (seg_count >= TABLE_DEPTH) begin
					w.status = ST_FULL;
				end else begin
					for (int i = seg_count; i > pos; i--)
						seg_table[i] = seg_table[i-1];
					seg_table[pos] = '{start: r.seg_start, length: r.seg_length};
					seg_count++;
				end
			end
			REQ_DUMP: begin
				if (seg_count == 0) begin
					w.status = ST_EMPTY;
				end else begin
					for (int i = 0; i < seg_count; i++) begin
						w.out_start  = seg_table[i].start;
						w.out_length = seg_table[i].length;
						w.last       = (i + 1 == seg_count);
						expected_words.push_back(w);
					end
					return;
				end
			end
			default: return;
		endcase
		expected_words.push_back(w);
	endfunction

	task automatic send_request(input req_type_t kind, input addr_t start, input len_t length);
		while (!steady && $urandom_range(99) < 26) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req.req_type   <= kind;
		req.seg_start  <= start;
		req.seg_length <= length;
		req_valid      <= 1'b1;
		predict_request('{req_type: kind, seg_start: start, seg_length: length});
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	always @(posedge clk) begin : check_words
		rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: status %0d start %0h length %0h last %0b",
					rsp.status, rsp.out_start, rsp.out_length, rsp.last);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					mismatches++;
				end
				if (rsp.out_start !== want.out_start) begin
					$error("out_start: expected %0h, actual %0h", want.out_start, rsp.out_start);
					mismatches++;
				end
				if (rsp.out_length !== want.out_length) begin
					$error("out_length: expected %0h, actual %0h", want.out_length,
						rsp.out_length);
					mismatches++;
				end
				if (rsp.last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, rsp.last);
					mismatches++;
				end
			end
		end
		rsp_ready <= steady || ($urandom_range(99) >= 26);
	end

	task automatic test_empty_dump();
		send_request(REQ_DUMP, '0, '0);
	endtask

	task automatic test_unknown_request();
		send_request(REQ_UNKNOWN, addr_t'(ADDR_MAX), len_t'(LEN_MAX));
	endtask

	task automatic test_release_merges();
		send_request(REQ_LOAD, 20'h00100, 21'h10);
		send_request(REQ_LOAD, 20'h00200, 21'h20);
		send_request(REQ_LOAD, addr_t'(ADDR_MAX), len_t'(LEN_MAX));
		send_request(REQ_RELEASE, 20'h00110, 21'h10);	// joins the one before
		send_request(REQ_RELEASE, 20'h001f0, 21'h10);	// joins the one after
		send_request(REQ_RELEASE, 20'h00120, 21'hd0);	// closes the gap
		send_request(REQ_RELEASE, 20'h00050, 21'h8);
		send_request(REQ_RELEASE, 20'h00000, 21'h0);	// zero length
		send_request(REQ_RELEASE, addr_t'(ADDR_MAX - 1), 21'h1);
	endtask

	task automatic test_full_table();
		for (int i = 0; i < 13; i++)
			send_request(REQ_LOAD, addr_t'(32'h1000 + i * 32'h100), 21'h40);
		send_request(REQ_RELEASE, 20'h80000, 21'h4);	// no neighbor, dropped
		send_request(REQ_RELEASE, 20'h00220, 21'h4);	// merges, so it fits
		send_request(REQ_DUMP, '0, '0);
	endtask

	function automatic len_t random_length();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return len_t'($urandom_range(64, 1));
		if (roll < 95)
			return len_t'($urandom_range(4096, 1));
		return len_t'($urandom_range(LEN_MAX, 1));
	endfunction

	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned roll;
		int          idx;
		req_type_t   kind;
		addr_t       start;
		len_t        length;
		span_t       lo;
		span_t       hi;
		sent = 0;
		while (sent < 93) begin
			steady = (sent >= 30 && sent < 60);
			roll   = $urandom_range(99);
			start  = addr_t'($urandom_range(ADDR_MAX));
			length = random_length();
			if (roll < 3) begin
				kind = REQ_UNKNOWN;
			end else if (roll < 15) begin
				kind = REQ_DUMP;
			end else if (roll < 40) begin
				kind = REQ_LOAD;
				if (seg_count > 0) begin
					lo = segment_end(seg_table[seg_count-1]) + span_t'($urandom_range(32));
					if (lo <= span_t'(ADDR_MAX))
						start = addr_t'(lo);
				end
			end else begin
				kind = REQ_RELEASE;
				if (seg_count > 0) begin
					idx = $urandom_range(seg_count - 1);
					case ($urandom_range(3))
						0: if (idx + 1 < seg_count) begin
							lo = segment_end(seg_table[idx]);
							hi = span_t'(seg_table[idx+1].start);
							if (lo < hi && hi - lo <= span_t'(LEN_MAX)) begin
								start  = addr_t'(lo);
								length = len_t'(hi - lo);
							end
						end
						1: begin
							lo = segment_end(seg_table[idx]);
							if (lo <= span_t'(ADDR_MAX))
								start = addr_t'(lo);
						end
						2: if (seg_table[idx].start > 0) begin
							hi     = span_t'(seg_table[idx].start);
							length = len_t'($urandom_range(hi < 64 ? hi : 64, 1));
							start  = addr_t'(hi - span_t'(length));
						end
						default: ;
					endcase
				end
			end
			send_request(kind, start, length);
			if (kind != REQ_UNKNOWN)
				sent++;
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		rsp_ready  = 1'b0;
		steady     = 1'b0;
		mismatches = 0;
		seg_count  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_dump();
		test_unknown_request();
		test_release_merges();
		test_full_table();
		test_random_traffic();

		req_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
